### sv/audio_compressor_gain_macros.svh
// ----------------------------------------------------------------------------
// audio_compressor_gain_macros: assertion macros
// Concurrent check macros shared by the compressor gain RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_COMPRESSOR_GAIN_MACROS_SVH
`define AUDIO_COMPRESSOR_GAIN_MACROS_SVH

`ifndef SYNTHESIS
// check that the consequent holds in the same cycle as the antecedent
`define ACG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acg: same-cycle check failed");
// check that the consequent holds in the cycle after the antecedent
`define ACG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acg: next-cycle check failed");
`else
`define ACG_ASSERT_IMPL(lbl, ante, cons)
`define ACG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/acg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_pkg: compressor gain package
// Widths, constants, register indexes and shared types of the gain computer.
// ----------------------------------------------------------------------------
package acg_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int THR_W    = 16;
  localparam int AMT_W    = 17;
  localparam int GAIN_W   = 17;
  localparam int LEVEL_W  = 16;
  localparam int ENV_W    = 24;
  localparam int ENV_FRAC = 8;

  // gain datapath widths
  localparam int NUM_W     = 49;
  localparam int DEN_W     = 49;
  localparam int DVD_W     = 64;
  localparam int QUO_W     = 17;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  // request queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [AMT_W-1:0]  UNITY   = 17'h10000;
  localparam logic [ENV_W-1:0]  ENV_MAX = 24'h800000;
  localparam logic [COEF_W-1:0] KNEE_K  = 16'd46858;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ATTACK    = 3'd0;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [IDX_W-1:0] REG_AMOUNT    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SOFT_KNEE = 3'd4;

  // request classes
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_UNITY = 2'd0;
  localparam kind_t KIND_HARD  = 2'd1;
  localparam kind_t KIND_SOFT  = 2'd2;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [COEF_W-1:0] att_coef;
    logic [COEF_W-1:0] rel_coef;
    logic [THR_W-1:0]  thr;
    logic [AMT_W-1:0]  amt;
    logic              soft_knee;
  } cfg_t;

  // one classified request in the queue
  typedef struct packed {
    kind_t            kind;
    logic [ENV_W-1:0] env;
  } job_t;

endpackage

### sv/acg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_in_if: sample channel
// Valid/ready channel carrying one signed audio sample per request.
// ----------------------------------------------------------------------------
interface acg_in_if import acg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### sv/acg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_out_if: gain channel
// Valid/ready channel carrying the gain factor and the envelope level.
// ----------------------------------------------------------------------------
interface acg_out_if import acg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GAIN_W-1:0]  gain;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output gain, output level, input ready);
  modport sink (input valid, input gain, input level, output ready);
endinterface

### sv/acg_queue.sv
`timescale 1ns / 1ps
`include "audio_compressor_gain_macros.svh"
// ----------------------------------------------------------------------------
// acg_queue: request queue
// Small FIFO of classified requests between the envelope front and the gain
// back end.
// ----------------------------------------------------------------------------
module acg_queue import acg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // store request payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // advance pointers and fill count; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `ACG_ASSERT_IMPL(a_q_no_overflow, push, !full)
  `ACG_ASSERT_IMPL(a_q_no_underflow, pop, !empty)

endmodule

### sv/acg_div.sv
`timescale 1ns / 1ps
`include "audio_compressor_gain_macros.svh"
// ----------------------------------------------------------------------------
// acg_div: iterative divider
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QUO_W bits, so the upper dividend bits seed the remainder directly.
// ----------------------------------------------------------------------------
module acg_div import acg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient
);

  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     low_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 take;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign take  = (trial >= {1'b0, dvs_r});

  assign busy     = busy_r;
  assign quotient = quo_r;

  // remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(dividend[DVD_W-1:QUO_W]);
      low_r <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  `ACG_ASSERT_IMPL(a_div_start_idle, start, !busy_r)

endmodule

### sv/acg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_front: envelope front end
// Accepts samples, updates the one-pole envelope and classifies each request
// as unity, hard knee or soft knee before queuing it.
// ----------------------------------------------------------------------------
module acg_front import acg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  acg_in_if.sink in_ch,
  output logic  push,
  output job_t  push_job,
  input  logic  full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MULA = 3'd1;
  localparam logic [2:0] F_MULB = 3'd2;
  localparam logic [2:0] F_SUM  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]               state_r;
  logic [2:0]               state_nxt;
  logic [ENV_W-1:0]         env_r;
  logic [ENV_W-1:0]         m_r;
  logic [COEF_W-1:0]        coef_r;
  logic [ENV_W+COEF_W-1:0]  p0_r;
  logic [ENV_W+COEF_W:0]    p1_r;
  logic [SAMPLE_W-1:0]      raw;
  logic [SAMPLE_W-1:0]      mag;
  logic [ENV_W-1:0]         m_in;
  logic [COEF_W:0]          coef_inv;
  logic [ENV_W+COEF_W+1:0]  sum;
  logic [ENV_W+1:0]         env_new;
  logic [ENV_W-1:0]         env_sat;
  logic [ENV_W-1:0]         thr_env;
  logic                     accept;
  kind_t                    kind;

  // magnitude of the sample, scaled to envelope precision
  assign raw    = $unsigned(in_ch.sample);
  assign mag    = raw[SAMPLE_W-1] ? (~raw + 16'd1) : raw;
  assign m_in   = {mag, {ENV_FRAC{1'b0}}};
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = (state_r == F_IDLE);

  // blend products, round and saturate
  assign coef_inv = UNITY - {1'b0, coef_r};
  assign sum      = (ENV_W+COEF_W+2)'(p0_r) + (ENV_W+COEF_W+2)'(p1_r)
                  + (ENV_W+COEF_W+2)'(32768);
  assign env_new  = sum[ENV_W+COEF_W+1:COEF_W];
  assign env_sat  = (env_new > (ENV_W+2)'(ENV_MAX)) ? ENV_MAX : env_new[ENV_W-1:0];

  // classify the request on the updated envelope
  assign thr_env = {cfg.thr, {ENV_FRAC{1'b0}}};
  always_comb begin
    if (cfg.soft_knee) begin
      kind = (env_r == '0) ? KIND_UNITY : KIND_SOFT;
    end else begin
      kind = (env_r <= thr_env) ? KIND_UNITY : KIND_HARD;
    end
  end

  assign push          = (state_r == F_PUSH) && !full;
  assign push_job.kind = kind;
  assign push_job.env  = env_r;

  // sequence one sample through the envelope update
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_MULA;
      F_MULA: state_nxt = F_MULB;
      F_MULB: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_PUSH;
      F_PUSH: if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture magnitude and pick attack or release
  always_ff @(posedge clk) begin
    if (accept) begin
      m_r    <= m_in;
      coef_r <= (m_in < env_r) ? cfg.rel_coef : cfg.att_coef;
    end
    if (state_r == F_MULA) begin
      p0_r <= env_r * coef_r;
    end
    if (state_r == F_MULB) begin
      p1_r <= m_r * coef_inv;
    end
  end

  // hold the envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (state_r == F_SUM) begin
      env_r <= env_sat;
    end
  end

endmodule

### sv/acg_back.sv
`timescale 1ns / 1ps
`include "audio_compressor_gain_macros.svh"
// ----------------------------------------------------------------------------
// acg_back: gain back end
// Pops requests; knee requests get the knee-curve numerator and denominator
// built with one multiply per step and a divide; every result is registered.
// ----------------------------------------------------------------------------
module acg_back import acg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  job_t  pop_job,
  input  logic  empty,
  output logic  pop,
  acg_out_if.source out_ch
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_TT   = 4'd1;
  localparam logic [3:0] B_ET   = 4'd2;
  localparam logic [3:0] B_EE   = 4'd3;
  localparam logic [3:0] B_KET  = 4'd4;
  localparam logic [3:0] B_KEE  = 4'd5;
  localparam logic [3:0] B_DEN  = 4'd6;
  localparam logic [3:0] B_ML   = 4'd7;
  localparam logic [3:0] B_MH   = 4'd8;
  localparam logic [3:0] B_DVD  = 4'd9;
  localparam logic [3:0] B_DIV  = 4'd10;
  localparam logic [3:0] B_OUT  = 4'd11;

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  kind_t              kind_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [31:0]        tt_r;
  logic [30:0]        et_r;
  logic [30:0]        ee_r;
  logic [46:0]        ket_r;
  logic [46:0]        kee_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [48:0]        pl_r;
  logic [33:0]        ph_r;
  logic               out_vld_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [LEVEL_W-1:0] level_r;

  logic [ENV_W:0]     lvl_sum;
  logic [31:0]        et_full;
  logic [31:0]        ee_full;
  logic [DVD_W-1:0]   dividend;
  logic               div_start;
  logic               div_busy;
  logic [QUO_W-1:0]   quotient;
  logic [GAIN_W:0]    g_sum;
  logic [GAIN_W-1:0]  g_calc;
  logic               out_free;
  logic               load;

  // round the envelope to Q1.15
  assign lvl_sum = (ENV_W+1)'(pop_job.env) + (ENV_W+1)'(128);

  // small products of the soft-knee terms
  assign et_full = {16'd0, lvl_r} * {16'd0, cfg.thr};
  assign ee_full = {16'd0, lvl_r} * {16'd0, lvl_r};

  // dividend is num*amt + den/2, kept modulo 2^64
  assign dividend = DVD_W'(pl_r) + {ph_r[31:0], 32'h0} + DVD_W'(den_r >> 1);
  assign div_start = (state_r == B_DVD);

  acg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // gain = quotient + 1 - amount, clamped to unity
  assign g_sum  = {1'b0, quotient} + (GAIN_W+1)'(UNITY) - (GAIN_W+1)'(cfg.amt);
  always_comb begin
    if (kind_r == KIND_UNITY) begin
      g_calc = UNITY;
    end else if (g_sum > (GAIN_W+1)'(UNITY)) begin
      g_calc = UNITY;
    end else begin
      g_calc = g_sum[GAIN_W-1:0];
    end
  end

  assign pop      = (state_r == B_IDLE) && !empty;
  assign out_free = !out_vld_r || out_ch.ready;
  assign load     = (state_r == B_OUT) && out_free;

  assign out_ch.valid = out_vld_r;
  assign out_ch.gain  = gain_r;
  assign out_ch.level = level_r;

  // sequence one request through the gain computation
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          unique case (pop_job.kind)
            KIND_HARD: state_nxt = B_ML;
            KIND_SOFT: state_nxt = B_TT;
            default:   state_nxt = B_OUT;
          endcase
        end
      end
      B_TT:  state_nxt = B_ET;
      B_ET:  state_nxt = B_EE;
      B_EE:  state_nxt = B_KET;
      B_KET: state_nxt = B_KEE;
      B_KEE: state_nxt = B_DEN;
      B_DEN: state_nxt = B_ML;
      B_ML:  state_nxt = B_MH;
      B_MH:  state_nxt = B_DVD;
      B_DVD: state_nxt = B_DIV;
      B_DIV: if (!div_busy) state_nxt = B_OUT;
      B_OUT: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // numerator and denominator datapath, one multiply per step
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= pop_job.kind;
      lvl_r  <= lvl_sum[ENV_W-1:ENV_FRAC];
      num_r  <= NUM_W'({cfg.thr, {ENV_FRAC{1'b0}}});
      den_r  <= DEN_W'(pop_job.env);
    end
    if (state_r == B_TT) begin
      tt_r <= cfg.thr * cfg.thr;
    end
    if (state_r == B_ET) begin
      et_r <= et_full[30:0];
    end
    if (state_r == B_EE) begin
      ee_r <= ee_full[30:0];
    end
    if (state_r == B_KET) begin
      ket_r <= KNEE_K * et_r;
    end
    if (state_r == B_KEE) begin
      kee_r <= KNEE_K * ee_r;
      num_r <= NUM_W'({tt_r, 16'h0}) + NUM_W'(ket_r);
    end
    if (state_r == B_DEN) begin
      den_r <= DEN_W'({tt_r, 16'h0}) + DEN_W'({et_r, 16'h0}) + DEN_W'(kee_r);
    end
    if (state_r == B_ML) begin
      pl_r <= num_r[31:0] * cfg.amt;
    end
    if (state_r == B_MH) begin
      ph_r <= num_r[NUM_W-1:32] * cfg.amt;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      gain_r  <= g_calc;
      level_r <= lvl_r;
    end
  end

  // output register valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  `ACG_ASSERT_NEXT(a_out_load, load, out_vld_r)

endmodule

### sv/audio_compressor_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_compressor_gain: compressor gain computer
// Envelope follower and hard/soft knee gain curve with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed Q1.15 sample per request; out_ch returns one
//   request per sample with the Q1.16 gain and the rounded Q1.15 envelope.
//   Configure over APB (attack, release, threshold, amount, soft knee at
//   byte addresses 0, 4, 8, 12, 16) only while the block is idle.
//   The front end takes one sample at a time (two multiplies, a sum, a push)
//   and queues up to 2 classified requests for the back end.
//   The back end handles one request at a time: unity requests go straight
//   to the output, knee requests run the 17-step divider (soft knee after
//   building its terms), so knee requests set the sustained sample rate.
//   Reset clears the envelope, the queue and the output register and loads
//   the register defaults (threshold full scale, everything else zero).
//   When out_ch stalls, the finished result holds in the output register,
//   the back end computes the next result, the queue fills, and then
//   in_ch.ready stays low.
// ----------------------------------------------------------------------------
module audio_compressor_gain import acg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  acg_in_if.sink            in_ch,
  acg_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [COEF_W-1:0] att_r;
  logic [COEF_W-1:0] rel_r;
  logic [THR_W-1:0]  thr_r;
  logic [AMT_W-1:0]  amt_r;
  logic              soft_r;
  logic              wr_en;
  logic [IDX_W-1:0]  reg_idx;
  cfg_t              cfg;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  job_t              push_job;
  job_t              pop_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  // register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r  <= '0;
      rel_r  <= '0;
      thr_r  <= 16'd32768;
      amt_r  <= '0;
      soft_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:    att_r  <= pwdata[COEF_W-1:0];
        REG_RELEASE:   rel_r  <= pwdata[COEF_W-1:0];
        REG_THRESHOLD: thr_r  <= pwdata[THR_W-1:0];
        REG_AMOUNT:    amt_r  <= pwdata[AMT_W-1:0];
        REG_SOFT_KNEE: soft_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:    prdata = DATA_W'(att_r);
      REG_RELEASE:   prdata = DATA_W'(rel_r);
      REG_THRESHOLD: prdata = DATA_W'(thr_r);
      REG_AMOUNT:    prdata = DATA_W'(amt_r);
      REG_SOFT_KNEE: prdata = DATA_W'(soft_r);
      default:       prdata = '0;
    endcase
  end

  // effective settings: zero threshold acts as one, amount saturates at unity
  assign cfg.att_coef  = att_r;
  assign cfg.rel_coef  = rel_r;
  assign cfg.thr       = (thr_r == '0) ? 16'd1 : thr_r;
  assign cfg.amt       = (amt_r > UNITY) ? UNITY : amt_r;
  assign cfg.soft_knee = soft_r;

  acg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  acg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  acg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .pop_job (pop_job),
    .empty   (empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
